[src/rate_monotonic_tick_scheduler_core_macros.svh]
// Assertion macros for the scheduler top level.
`ifndef RATE_MONOTONIC_TICK_SCHEDULER_CORE_MACROS_SVH
`define RATE_MONOTONIC_TICK_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define RMTS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RMTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/rmts_pkg.sv]
// Package: types and constants of the rate-monotonic tick scheduler.
package rmts_pkg;

	localparam int TASKS_DEF = 8;
	localparam int WORD_W    = 16;
	localparam int IDX_W     = 3;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 8;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	// Per-slot control from the top level
	typedef struct packed {
		logic load;
		logic tick;
		logic grant;
	} slot_ctrl_t;

	// Per-slot status toward the top level
	typedef struct packed {
		logic enabled;
		logic busy;
		logic pending;
		logic miss;
	} slot_stat_t;

endpackage

[src/rmts_task_slot.sv]
// One task slot: stored task entry, countdown and remaining work.
module rmts_task_slot (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rmts_pkg::slot_ctrl_t           ctrl,
	input  logic [rmts_pkg::WORD_W-1:0]    run_length,
	input  logic [rmts_pkg::WORD_W-1:0]    task_period,
	output rmts_pkg::slot_stat_t           stat
);

	logic [rmts_pkg::WORD_W-1:0] job_q;
	logic [rmts_pkg::WORD_W-1:0] period_q;
	logic [rmts_pkg::WORD_W-1:0] work_q;
	logic [rmts_pkg::WORD_W-1:0] countdown_q;
	logic                        en_q;

	logic                        release_now;
	logic [rmts_pkg::WORD_W-1:0] work_rel;

	// Release when the countdown has run out; reload the work then
	always_comb begin
		release_now = en_q && (countdown_q == '0);
		work_rel    = release_now ? job_q : work_q;
		stat.enabled = en_q;
		stat.busy    = (work_q != '0);
		stat.pending = en_q && (work_rel != '0);
		stat.miss    = release_now && (work_q != '0);
	end

	// Load a slot, or advance it by one tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_q       <= '0;
			period_q    <= rmts_pkg::WORD_W'(1);
			work_q      <= '0;
			countdown_q <= '0;
			en_q        <= 1'b0;
		end else if (ctrl.load) begin
			job_q       <= run_length;
			period_q    <= (task_period == '0) ? rmts_pkg::WORD_W'(1) : task_period;
			work_q      <= '0;
			countdown_q <= '0;
			en_q        <= (run_length != '0);
		end else if (ctrl.tick && en_q) begin
			work_q      <= ctrl.grant ? work_rel - rmts_pkg::WORD_W'(1) : work_rel;
			countdown_q <= release_now ? period_q - rmts_pkg::WORD_W'(1)
			                           : countdown_q - rmts_pkg::WORD_W'(1);
		end
	end

endmodule

[src/rate_monotonic_tick_scheduler_core.sv]
// Top level of the rate-monotonic tick scheduler.
//
// Input stream (s_axis): each word is a load or a tick, selected by tuser.
// A load writes one task slot (run length and period) and gives no result;
// a tick advances every enabled task by one time unit and gives one result
// word on m_axis: the task that ran, an idle flag, and a deadline-miss flag
// with the lowest missing task index.
// An accepted word is held in the input register; when it advances, a
// tick's result is written into the output register and presented from
// there. Throughput is one word per cycle while no held result stalls a tick:
// all slots update in parallel in one pass, the running task chosen by a
// priority encoder over the pending slots.
// Reset clears every slot: all tasks disabled, periods one, no work left.
// When m_axis stalls, the result is held and the input register holds the
// next tick; loads keep draining while a result waits.
module rate_monotonic_tick_scheduler_core #(
	parameter int TASKS = rmts_pkg::TASKS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [2:0] task_index, [18:3] run_length, [34:19] task_period, [39:35] zero
	input  logic [rmts_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// [0] command
	input  logic [0:0]                       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [2:0] running_task, [3] idle, [4] deadline_miss, [7:5] missed_task
	output logic [rmts_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

	`include "rate_monotonic_tick_scheduler_core_macros.svh"

	localparam int SelW = (TASKS > 1) ? $clog2(TASKS) : 1;
	localparam int ExtW = (SelW > rmts_pkg::IDX_W) ? SelW : rmts_pkg::IDX_W;

	logic                             valid_s1;
	rmts_pkg::cmd_t                   cmd_s1;
	logic [rmts_pkg::IDX_W-1:0]       index_s1;
	logic [rmts_pkg::WORD_W-1:0]      length_s1;
	logic [rmts_pkg::WORD_W-1:0]      period_s1;
	logic                             adv_s1;
	logic                             tick_s1;

	rmts_pkg::slot_ctrl_t             ctrl   [TASKS];
	rmts_pkg::slot_stat_t             stat   [TASKS];
	logic [TASKS-1:0]                 pending_vec;
	logic [TASKS-1:0]                 miss_vec;
	logic [TASKS-1:0]                 grant_vec;
	logic [TASKS-1:0]                 stray_vec;

	logic                             found;
	logic [SelW-1:0]                  runner;
	logic                             missed_any;
	logic [SelW-1:0]                  missed;
	logic [ExtW-1:0]                  runner_ext;
	logic [ExtW-1:0]                  missed_ext;

	logic                             out_valid_q;
	logic [rmts_pkg::M_TDATA_W-1:0]   out_data_q;

	// Advance the input register when it holds a load or the result slot frees
	assign adv_s1        = valid_s1 && ((cmd_s1 == rmts_pkg::CMD_LOAD) ||
	                                    !out_valid_q || m_axis_tready);
	assign tick_s1       = adv_s1 && (cmd_s1 == rmts_pkg::CMD_TICK);
	assign s_axis_tready = !valid_s1 || adv_s1;

	// Capture the input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1    <= rmts_pkg::cmd_t'(s_axis_tuser[0]);
			index_s1  <= s_axis_tdata[2:0];
			length_s1 <= s_axis_tdata[18:3];
			period_s1 <= s_axis_tdata[34:19];
		end
	end

	// Task slots
	for (genvar i = 0; i < TASKS; i++) begin : g_slot
		always_comb begin
			ctrl[i].load  = adv_s1 && (cmd_s1 == rmts_pkg::CMD_LOAD) &&
			                (32'(index_s1) == i);
			ctrl[i].tick  = tick_s1;
			ctrl[i].grant = tick_s1 && found && (runner == SelW'(i));
			pending_vec[i] = stat[i].pending;
			miss_vec[i]    = stat[i].miss;
			grant_vec[i]   = ctrl[i].grant;
			stray_vec[i]   = stat[i].busy && !stat[i].enabled;
		end

		rmts_task_slot u_slot (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl[i]),
			.run_length  (length_s1),
			.task_period (period_s1),
			.stat        (stat[i])
		);
	end

	// Pick the lowest pending index and the lowest missing index
	always_comb begin
		found      = 1'b0;
		runner     = '0;
		missed_any = 1'b0;
		missed     = '0;
		for (int k = TASKS - 1; k >= 0; k--) begin
			if (pending_vec[k]) begin
				found  = 1'b1;
				runner = SelW'(k);
			end
			if (miss_vec[k]) begin
				missed_any = 1'b1;
				missed     = SelW'(k);
			end
		end
		runner_ext = ExtW'(runner);
		missed_ext = ExtW'(missed);
	end

	// Hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_s1) begin
			out_data_q <= {missed_ext[2:0], missed_any, !found, runner_ext[2:0]};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	`RMTS_ASSERT_SAME(a_one_runner, 1'b1, $onehot0(grant_vec),
		"more than one task granted in a tick")
	`RMTS_ASSERT_SAME(a_work_only_enabled, 1'b1, stray_vec == '0,
		"disabled task holds pending work")
	`RMTS_ASSERT_SAME(a_result_from_tick, $rose(out_valid_q), $past(tick_s1),
		"result word appeared without a tick")
	`RMTS_ASSERT_NEXT(a_stall_holds, valid_s1 && !adv_s1,
		valid_s1 && $stable(cmd_s1) && $stable(period_s1),
		"input register changed while stalled")

endmodule

[verif/testbench.sv]
// Self-checking testbench of the rate-monotonic tick scheduler core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS        = rmts_pkg::TASKS_DEF;
	localparam int IDX_W        = rmts_pkg::IDX_W;
	localparam int WORD_W       = rmts_pkg::WORD_W;
	localparam int S_TDATA_W    = rmts_pkg::S_TDATA_W;
	localparam int M_TDATA_W    = rmts_pkg::M_TDATA_W;
	localparam int RANDOM_WORDS = 850;
	localparam int STEADY_FIRST = 300;
	localparam int STEADY_LAST  = 449;
	localparam int IDLE_PCT     = 34;
	localparam int TICK_PCT     = 75;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_SHOWN    = 10;

	// Result word, laid out as m_axis_tdata from the top bit down
	typedef struct packed {
		logic [IDX_W-1:0] missed_task;
		logic             deadline_miss;
		logic             idle;
		logic [IDX_W-1:0] running_task;
	} tick_result_t;

	typedef struct {
		rmts_pkg::cmd_t    cmd;
		logic [IDX_W-1:0]  task_index;
		logic [WORD_W-1:0] run_length;
		logic [WORD_W-1:0] task_period;
		bit                typed;
		tick_result_t      typed_result;
	} sched_word_t;

	localparam tick_result_t IDLE_RESULT =
		'{missed_task: '0, deadline_miss: 1'b0, idle: 1'b1, running_task: '0};
	localparam tick_result_t TASK0_RAN =
		'{missed_task: '0, deadline_miss: 1'b0, idle: 1'b0, running_task: '0};

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;
	logic [0:0]           s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;

	// Side information that travels with the word on the input bus
	bit           word_typed;
	tick_result_t word_typed_result;
	bit           no_stall;

	// Predicted scheduler state
	logic [WORD_W-1:0] job_length_p [SLOTS];
	logic [WORD_W-1:0] period_p     [SLOTS];
	logic [WORD_W-1:0] work_left_p  [SLOTS];
	logic [WORD_W-1:0] countdown_p  [SLOTS];
	logic              enabled_p    [SLOTS];

	tick_result_t expected_ticks[$];
	sched_word_t  directed_words[$];
	int           mismatches;
	int           cycles;

	rate_monotonic_tick_scheduler_core #(
		.TASKS(SLOTS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Release due jobs, then run the highest-priority pending task for one unit
	function automatic tick_result_t advance_tick();
		tick_result_t r;
		bit           found;
		r = '0;
		found = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			if (enabled_p[i]) begin
				if (countdown_p[i] == '0) begin
					if (work_left_p[i] != '0 && !r.deadline_miss) begin
						r.deadline_miss = 1'b1;
						r.missed_task = i[IDX_W-1:0];
					end
					work_left_p[i] = job_length_p[i];
					countdown_p[i] = period_p[i] - 1'b1;
				end else begin
					countdown_p[i] = countdown_p[i] - 1'b1;
				end
			end
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (!found && enabled_p[i] && work_left_p[i] != '0) begin
				found = 1'b1;
				r.running_task = i[IDX_W-1:0];
			end
		end
		if (found) begin
			work_left_p[r.running_task] = work_left_p[r.running_task] - 1'b1;
		end
		r.idle = !found;
		return r;
	endfunction

	function automatic sched_word_t make_word(rmts_pkg::cmd_t c, int idx, int len, int per,
			bit typed = 1'b0, tick_result_t res = '0);
		sched_word_t w;
		w.cmd = c;
		w.task_index = idx[IDX_W-1:0];
		w.run_length = len[WORD_W-1:0];
		w.task_period = per[WORD_W-1:0];
		w.typed = typed;
		w.typed_result = res;
		return w;
	endfunction

	task automatic note_mismatch(string what, tick_result_t want, tick_result_t got);
		mismatches++;
		if (mismatches <= MAX_SHOWN) begin
			$write("%0t %s: expected run=%0d idle=%0b miss=%0b missed=%0d, ",
				$realtime, what, want.running_task, want.idle, want.deadline_miss,
				want.missed_task);
			$display("got run=%0d idle=%0b miss=%0b missed=%0d",
				got.running_task, got.idle, got.deadline_miss, got.missed_task);
		end
	endtask

	// Present one word after a random gap and hold it until accepted
	task automatic send_word(sched_word_t w);
		while (!no_stall && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= w.cmd;
		s_axis_tdata <= {{(S_TDATA_W - 2 * WORD_W - IDX_W){1'b0}},
			w.task_period, w.run_length, w.task_index};
		word_typed <= w.typed;
		word_typed_result <= w.typed_result;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Stall the result side at random outside the steady stretch
	always @(negedge clk) begin
		m_axis_tready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Track accepted input words and check result words in order
	always @(posedge clk) begin : monitor
		tick_result_t predicted;
		tick_result_t got;
		tick_result_t want;
		int           slot;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser[0] == rmts_pkg::CMD_TICK) begin
					predicted = advance_tick();
					expected_ticks.push_back(word_typed ? word_typed_result : predicted);
				end else begin
					slot = int'(s_axis_tdata[IDX_W-1:0]);
					if (slot < SLOTS) begin
						job_length_p[slot] = s_axis_tdata[IDX_W +: WORD_W];
						period_p[slot] = s_axis_tdata[IDX_W + WORD_W +: WORD_W];
						if (period_p[slot] == '0) begin
							period_p[slot] = WORD_W'(1);
						end
						work_left_p[slot] = '0;
						countdown_p[slot] = '0;
						enabled_p[slot] = s_axis_tdata[IDX_W +: WORD_W] != '0;
					end
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = tick_result_t'(m_axis_tdata);
				if (expected_ticks.size() == 0) begin
					note_mismatch("unexpected result word", '0, got);
				end else begin
					want = expected_ticks.pop_front();
					if (got.running_task != want.running_task || got.idle != want.idle ||
							got.deadline_miss != want.deadline_miss ||
							got.missed_task != want.missed_task) begin
						note_mismatch("result mismatch", want, got);
					end
				end
			end
		end
	end

	initial begin : stimulus
		sched_word_t w;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = rmts_pkg::CMD_LOAD;
		m_axis_tready = 1'b0;
		word_typed = 1'b0;
		word_typed_result = '0;
		no_stall = 1'b0;
		mismatches = 0;
		cycles = 0;
		for (int i = 0; i < SLOTS; i++) begin
			job_length_p[i] = '0;
			period_p[i] = WORD_W'(1);
			work_left_p[i] = '0;
			countdown_p[i] = '0;
			enabled_p[i] = 1'b0;
		end

		// Directed words: reset state, zero period, extremes, overload, disable
		directed_words.push_back(make_word(rmts_pkg::CMD_TICK, 0, 0, 1, 1'b1, IDLE_RESULT));
		directed_words.push_back(make_word(rmts_pkg::CMD_LOAD, 0, 1, 0));
		directed_words.push_back(make_word(rmts_pkg::CMD_TICK, 0, 0, 1, 1'b1, TASK0_RAN));
		directed_words.push_back(make_word(rmts_pkg::CMD_TICK, 7, 65535, 65535));
		directed_words.push_back(make_word(rmts_pkg::CMD_LOAD, 7, 65535, 65535));
		directed_words.push_back(make_word(rmts_pkg::CMD_TICK, 0, 0, 1));
		directed_words.push_back(make_word(rmts_pkg::CMD_TICK, 0, 0, 1));
		directed_words.push_back(make_word(rmts_pkg::CMD_LOAD, 0, 2, 1));
		directed_words.push_back(make_word(rmts_pkg::CMD_TICK, 0, 0, 1));
		directed_words.push_back(make_word(rmts_pkg::CMD_TICK, 0, 0, 1));
		directed_words.push_back(make_word(rmts_pkg::CMD_TICK, 0, 0, 1));
		directed_words.push_back(make_word(rmts_pkg::CMD_LOAD, 0, 0, 1));
		directed_words.push_back(make_word(rmts_pkg::CMD_TICK, 0, 0, 1));
		directed_words.push_back(make_word(rmts_pkg::CMD_LOAD, 7, 0, 65535));
		directed_words.push_back(make_word(rmts_pkg::CMD_TICK, 0, 0, 1, 1'b1, IDLE_RESULT));
		directed_words.push_back(make_word(rmts_pkg::CMD_LOAD, 3, 3, 2));
		directed_words.push_back(make_word(rmts_pkg::CMD_LOAD, 5, 1, 3));
		for (int i = 0; i < 6; i++) begin
			directed_words.push_back(make_word(rmts_pkg::CMD_TICK, 0, 0, 1));
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_words[i]) begin
			send_word(directed_words[i]);
		end

		// Random words: mostly ticks, loads with short jobs and periods
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			no_stall <= (n >= STEADY_FIRST && n <= STEADY_LAST);
			w.cmd = ($urandom_range(99) < TICK_PCT) ? rmts_pkg::CMD_TICK : rmts_pkg::CMD_LOAD;
			w.task_index = IDX_W'($urandom_range(SLOTS - 1));
			case ($urandom_range(9))
				0: w.run_length = '0;
				1: w.run_length = WORD_W'($urandom);
				2: w.run_length = '1;
				default: w.run_length = WORD_W'($urandom_range(4, 1));
			endcase
			case ($urandom_range(9))
				0: w.task_period = '0;
				1, 2: w.task_period = WORD_W'($urandom);
				3: w.task_period = '1;
				default: w.task_period = WORD_W'($urandom_range(12, 1));
			endcase
			w.typed = 1'b0;
			w.typed_result = '0;
			send_word(w);
		end
		s_axis_tvalid <= 1'b0;
		no_stall <= 1'b0;

		// Drain outstanding results, then hold for stray words
		while (expected_ticks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_ticks.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/rmts_pkg.sv
src/rmts_task_slot.sv
src/rate_monotonic_tick_scheduler_core.sv
verif/testbench.sv
